FILE: rtl/core/potl_pkg.sv
// potl_pkg: constants, widths and codes for the priority ordered task lists.
// No dependencies; used by potl_if.sv and priority_ordered_task_lists_top.sv.
package potl_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_LISTS = 4;

    // field widths
    localparam int TID_W  = 4;   // task_id field
    localparam int TASK_W = 5;   // task id including the "none" code
    localparam int LID_W  = 2;   // list_id field
    localparam int LIST_W = 3;   // list index including the "none" code
    localparam int PRIO_W = 8;
    localparam int CMD_W  = 2;
    localparam int ST_W   = 3;
    localparam int CNT_W  = 5;   // task_count register

    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [TASK_W-1:0] NO_TASK = TASK_W'(MAX_TASKS);
    localparam logic [LIST_W-1:0] NO_LIST = LIST_W'(NUM_LISTS);

    localparam logic [CNT_W-1:0]  TASK_COUNT_RST = CNT_W'(16);
    localparam logic [APB_AW-1:0] ADDR_TASK_COUNT = APB_AW'(0);

    // commands
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // result status
    localparam logic [ST_W-1:0] ST_DONE      = 3'd0;
    localparam logic [ST_W-1:0] ST_ALREADY   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_IN    = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [ST_W-1:0] ST_IDLE_RM   = 3'd4;
    localparam logic [ST_W-1:0] ST_OTHER     = 3'd5;

endpackage

FILE: rtl/core/potl_if.sv
// potl_cmd_if / potl_rsp_if: valid/ready channels for commands and results.
// Depends on potl_pkg.
interface potl_cmd_if import potl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [TID_W-1:0]  task_id;
    logic [LID_W-1:0]  list_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, command, task_id, list_id, priority_req, input ready);
    modport sink   (input valid, command, task_id, list_id, priority_req, output ready);
endinterface

interface potl_rsp_if import potl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [TASK_W-1:0] head_task;
    logic [LIST_W-1:0] task_list;

    modport source (output valid, status, head_task, task_list, input ready);
    modport sink   (input valid, status, head_task, task_list, output ready);
endinterface

FILE: rtl/core/priority_ordered_task_lists_top.sv
// Priority ordered task lists: sorted singly linked lists over a task table.
// Read head reports the list head. Insert walks the list (<= MAX_TASKS - 1 link memory reads),
// writes the entry, relinks any predecessor; remove reads the successor, walks, then unlinks.
// Throughput: one item at a time; next item accepted the cycle after its result is staged.
// Reset (rst_n, async low): lists empty, no task in a list, task_count = 16.
// Depends on potl_pkg and potl_if.sv.
module priority_ordered_task_lists_top
    import potl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    // item channels
    potl_cmd_if.sink           cmd,
    potl_rsp_if.source         rsp
);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_WALK    = 4'd2;  // insert: scan for first lower priority
    localparam logic [3:0] S_INS_T   = 4'd3;  // insert: write new task entry
    localparam logic [3:0] S_INS_P   = 4'd4;  // insert: relink predecessor
    localparam logic [3:0] S_RM_T    = 4'd5;  // remove: successor of task arrives
    localparam logic [3:0] S_RM_WALK = 4'd6;  // remove: scan for predecessor
    localparam logic [3:0] S_RM_FIN  = 4'd7;  // remove: unlink task entry
    localparam logic [3:0] S_RESP    = 4'd8;  // stage result into output register

    // latched item
    logic [CMD_W-1:0]  cmd_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [LID_W-1:0]  lid_reg;
    logic [PRIO_W-1:0] prio_reg;

    // ---------------------------------------------------------------
    // Config register
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] task_count_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TASK_COUNT);
    assign prdata = (paddr == ADDR_TASK_COUNT) ? APB_DW'(task_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= TASK_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            task_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Link and priority memories: one write, one registered read each.
    // Only entries of tasks in a list are ever read, and those were
    // written on insert, so no clearing is needed.
    // ---------------------------------------------------------------
    logic [TASK_W-1:0] link_mem [MAX_TASKS];
    logic [PRIO_W-1:0] prio_mem [MAX_TASKS];

    logic              mem_re;
    logic [TID_W-1:0]  mem_raddr;
    logic [TASK_W-1:0] link_rd_reg;
    logic [PRIO_W-1:0] prio_rd_reg;

    logic              link_we;
    logic [TID_W-1:0]  link_waddr;
    logic [TASK_W-1:0] link_wdata;
    logic              prio_we;

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            link_rd_reg <= link_mem[mem_raddr];
            prio_rd_reg <= prio_mem[mem_raddr];
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (prio_we)
        begin
            prio_mem[tid_reg] <= prio_reg;
        end
    end

    // ---------------------------------------------------------------
    // List heads and membership: small, reset to empty / none.
    // ---------------------------------------------------------------
    logic [TASK_W-1:0] head_reg [NUM_LISTS];
    logic [LIST_W-1:0] memb_reg [MAX_TASKS];

    logic              head_we;
    logic [LID_W-1:0]  head_widx;
    logic [TASK_W-1:0] head_wdata;
    logic              memb_we;
    logic [LIST_W-1:0] memb_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LISTS; i++)
            begin
                head_reg[i] <= NO_TASK;
            end
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                memb_reg[i] <= NO_LIST;
            end
        end
        else
        begin
            if (head_we)
            begin
                head_reg[head_widx] <= head_wdata;
            end
            if (memb_we)
            begin
                memb_reg[tid_reg] <= memb_wdata;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    logic [3:0]        state_reg, state_next;

    // walk pointers and staged result
    logic [TASK_W-1:0] cur_reg, cur_next;
    logic [TASK_W-1:0] prev_reg, prev_next;
    logic [TASK_W-1:0] tnext_reg, tnext_next;
    logic [LID_W-1:0]  sel_reg, sel_next;        // list whose head is reported
    logic [ST_W-1:0]   res_status_reg, res_status_next;
    logic [LIST_W-1:0] res_list_reg, res_list_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_status_reg;
    logic [TASK_W-1:0] out_head_reg;
    logic [LIST_W-1:0] out_list_reg;
    logic              out_load;

    logic              cmd_acc;
    logic              tid_ok;
    logic [LIST_W-1:0] memb_t;
    logic [TASK_W-1:0] tid_ext;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_acc   = cmd.valid && cmd.ready;

    assign tid_ext = TASK_W'(tid_reg);
    assign tid_ok  = CNT_W'(tid_reg) < task_count_reg;
    assign memb_t  = memb_reg[tid_reg];

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        tnext_next      = tnext_reg;
        sel_next        = sel_reg;
        res_status_next = res_status_reg;
        res_list_next   = res_list_reg;

        mem_re     = 1'b0;
        mem_raddr  = tid_reg;
        link_we    = 1'b0;
        link_waddr = tid_reg;
        link_wdata = NO_TASK;
        prio_we    = 1'b0;
        head_we    = 1'b0;
        head_widx  = lid_reg;
        head_wdata = tid_ext;
        memb_we    = 1'b0;
        memb_wdata = NO_LIST;
        out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                sel_next      = lid_reg;
                res_status_next = ST_DONE;
                res_list_next = NO_LIST;
                state_next    = S_RESP;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (!tid_ok)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (memb_t == LIST_W'(lid_reg))
                    begin
                        res_status_next = ST_ALREADY;
                        res_list_next   = memb_t;
                    end
                    else if (memb_t != NO_LIST)
                    begin
                        res_status_next = ST_OTHER;
                        res_list_next   = memb_t;
                    end
                    else
                    begin
                        prev_next = NO_TASK;
                        cur_next  = head_reg[lid_reg];
                        if (head_reg[lid_reg] == NO_TASK)
                        begin
                            state_next = S_INS_T;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg[lid_reg][TID_W-1:0];
                            state_next = S_WALK;
                        end
                    end
                end
                else if (cmd_reg == CMD_REMOVE)
                begin
                    if (tid_reg == '0)
                    begin
                        // idle task stays put
                        res_status_next = ST_IDLE_RM;
                        res_list_next   = memb_reg[0];
                    end
                    else if (!tid_ok)
                    begin
                        res_status_next = ST_INVALID;
                    end
                    else if (memb_t == NO_LIST)
                    begin
                        res_status_next = ST_NOT_IN;
                    end
                    else
                    begin
                        sel_next   = memb_t[LID_W-1:0];
                        mem_re     = 1'b1;
                        mem_raddr  = tid_reg;
                        state_next = S_RM_T;
                    end
                end
            end

            S_WALK:
            begin
                // rd data belongs to cur_reg
                if (prio_rd_reg < prio_reg)
                begin
                    state_next = S_INS_T;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rd_reg;
                    if (link_rd_reg == NO_TASK)
                    begin
                        state_next = S_INS_T;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = link_rd_reg[TID_W-1:0];
                    end
                end
            end

            S_INS_T:
            begin
                link_we         = 1'b1;
                link_wdata      = cur_reg;
                prio_we         = 1'b1;
                memb_we         = 1'b1;
                memb_wdata      = LIST_W'(lid_reg);
                res_status_next = ST_DONE;
                res_list_next   = LIST_W'(lid_reg);
                if (prev_reg == NO_TASK)
                begin
                    head_we    = 1'b1;
                    head_widx  = lid_reg;
                    head_wdata = tid_ext;
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_INS_P;
                end
            end

            S_INS_P:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg[TID_W-1:0];
                link_wdata = tid_ext;
                state_next = S_RESP;
            end

            S_RM_T:
            begin
                tnext_next = link_rd_reg;
                if (head_reg[sel_reg] == tid_ext)
                begin
                    head_we    = 1'b1;
                    head_widx  = sel_reg;
                    head_wdata = link_rd_reg;
                    state_next = S_RM_FIN;
                end
                else
                begin
                    cur_next   = head_reg[sel_reg];
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg[sel_reg][TID_W-1:0];
                    state_next = S_RM_WALK;
                end
            end

            S_RM_WALK:
            begin
                if (link_rd_reg == tid_ext)
                begin
                    link_we    = 1'b1;
                    link_waddr = cur_reg[TID_W-1:0];
                    link_wdata = tnext_reg;
                    state_next = S_RM_FIN;
                end
                else if (link_rd_reg == NO_TASK)
                begin
                    state_next = S_RM_FIN;
                end
                else
                begin
                    cur_next  = link_rd_reg;
                    mem_re    = 1'b1;
                    mem_raddr = link_rd_reg[TID_W-1:0];
                end
            end

            S_RM_FIN:
            begin
                link_we         = 1'b1;
                link_wdata      = NO_TASK;
                memb_we         = 1'b1;
                memb_wdata      = NO_LIST;
                res_status_next = ST_DONE;
                res_list_next   = NO_LIST;
                state_next      = S_RESP;
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            cmd_reg  <= cmd.command;
            tid_reg  <= cmd.task_id;
            lid_reg  <= LID_W'(cmd.list_id % NUM_LISTS);
            prio_reg <= cmd.priority_req;
        end
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        tnext_reg      <= tnext_next;
        sel_reg        <= sel_next;
        res_status_reg <= res_status_next;
        res_list_reg   <= res_list_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_head_reg   <= head_reg[sel_reg];
            out_list_reg   <= res_list_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.head_task = out_head_reg;
    assign rsp.task_list = out_list_reg;

`ifndef ASSERT_OFF
    // a walk never follows the end-of-list marker
    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK || state_reg == S_RM_WALK) |-> cur_reg != NO_TASK)
        else $error("walk pointer at end of list");

    // a task just linked in is recorded in its target list
    a_ins_memb: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INS_T |=> memb_reg[tid_reg] == LIST_W'(lid_reg))
        else $error("membership not updated on insert");

    // a removed task is no longer the head of the list it left
    a_rm_head: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RM_FIN |-> head_reg[sel_reg] != tid_ext)
        else $error("removed task still at list head");

    // results are staged only from the response state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_RESP)
        else $error("result appeared outside response state");
`endif

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for priority_ordered_task_lists_top: a directed table, then random traffic.
// It predicts untyped results from its copy of the lists. Needs potl_pkg, potl_if.sv, the top.
module testbench;
    import potl_pkg::*;

    // Command 3 is decoded as a second form of read head.
    localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;

    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no handshake of any kind
    localparam int LONG_HOLD      = 300;    // receiver hold-off for the pressure test
    localparam int DRAIN_TAIL     = 40;     // idle tail before the final verdict

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [TID_W-1:0]  tid;
        logic [LID_W-1:0]  lid;
        logic [PRIO_W-1:0] prio;
    } list_cmd_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [TASK_W-1:0] head;
        logic [LIST_W-1:0] lst;
    } list_rsp_t;

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // One row of the directed table: either an item or a task_count write.
    // Where typed is set, want holds the result read straight off the spec.
    typedef struct packed {
        row_kind_t         kind;
        logic [CMD_W-1:0]  op;
        logic [TID_W-1:0]  tid;
        logic [LID_W-1:0]  lid;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  cfgv;
        logic              typed;
        list_rsp_t         want;
    } dir_row_t;

    localparam int DIR_ROWS = 27;

    // Walk: empty reads, the idle-task guard, sorted inserts with ties, removal at
    // head, middle and tail, then task_count lowered to 8 and 1 and raised past 16.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_ITEM, CMD_READ,     4'd0,  2'd0, 8'd0,   5'd0,  1'b1, '{ST_DONE, NO_TASK, NO_LIST}},
        '{ROW_ITEM, CMD_READ,     4'd15, 2'd3, 8'd255, 5'd0,  1'b1, '{ST_DONE, NO_TASK, NO_LIST}},
        '{ROW_ITEM, CMD_REMOVE,   4'd0,  2'd0, 8'd0,   5'd0,  1'b1, '{ST_IDLE_RM, NO_TASK, NO_LIST}},
        '{ROW_ITEM, CMD_REMOVE,   4'd5,  2'd1, 8'd0,   5'd0,  1'b1, '{ST_NOT_IN, NO_TASK, NO_LIST}},
        '{ROW_ITEM, CMD_INSERT,   4'd0,  2'd0, 8'd0,   5'd0,  1'b1, '{ST_DONE, 5'd0, 3'd0}},
        '{ROW_ITEM, CMD_INSERT,   4'd15, 2'd0, 8'd255, 5'd0,  1'b1, '{ST_DONE, 5'd15, 3'd0}},
        '{ROW_ITEM, CMD_INSERT,   4'd15, 2'd0, 8'd7,   5'd0,  1'b1, '{ST_ALREADY, 5'd15, 3'd0}},
        '{ROW_ITEM, CMD_INSERT,   4'd15, 2'd3, 8'd9,   5'd0,  1'b1, '{ST_OTHER, NO_TASK, 3'd0}},
        '{ROW_ITEM, CMD_REMOVE,   4'd0,  2'd2, 8'd0,   5'd0,  1'b1, '{ST_IDLE_RM, NO_TASK, 3'd0}},
        '{ROW_ITEM, CMD_INSERT,   4'd3,  2'd0, 8'd0,   5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd4,  2'd0, 8'd255, 5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd7,  2'd0, 8'd128, 5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd10, 2'd1, 8'd170, 5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd9,  2'd2, 8'd85,  5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_REMOVE,   4'd3,  2'd3, 8'd0,   5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_REMOVE,   4'd15, 2'd0, 8'd0,   5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_REMOVE,   4'd7,  2'd1, 8'd0,   5'd0,  1'b0, '0},
        '{ROW_ITEM, CMD_READ_ALT, 4'd2,  2'd0, 8'd0,   5'd0,  1'b0, '0},
        '{ROW_CFG,  CMD_READ,     4'd0,  2'd0, 8'd0,   5'd8,  1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd8,  2'd1, 8'd1,   5'd0,  1'b1, '{ST_INVALID, 5'd10, NO_LIST}},
        '{ROW_ITEM, CMD_REMOVE,   4'd12, 2'd2, 8'd0,   5'd0,  1'b1, '{ST_INVALID, 5'd9, NO_LIST}},
        '{ROW_CFG,  CMD_READ,     4'd0,  2'd0, 8'd0,   5'd1,  1'b0, '0},
        '{ROW_ITEM, CMD_REMOVE,   4'd4,  2'd0, 8'd0,   5'd0,  1'b1, '{ST_INVALID, 5'd4, NO_LIST}},
        '{ROW_ITEM, CMD_INSERT,   4'd0,  2'd0, 8'd77,  5'd0,  1'b1, '{ST_ALREADY, 5'd4, 3'd0}},
        '{ROW_CFG,  CMD_READ,     4'd0,  2'd0, 8'd0,   5'd31, 1'b0, '0},
        '{ROW_ITEM, CMD_INSERT,   4'd14, 2'd3, 8'd200, 5'd0,  1'b1, '{ST_DONE, 5'd14, 3'd3}},
        '{ROW_ITEM, CMD_REMOVE,   4'd14, 2'd0, 8'd0,   5'd0,  1'b1, '{ST_DONE, NO_TASK, NO_LIST}}
    };

    // task_count for each random phase; 31 checks the clamp to MAX_TASKS
    localparam int PHASES = 8;
    localparam logic [CNT_W-1:0] PHASE_COUNT [PHASES] = '{
        5'd16, 5'd5, 5'd1, 5'd12, 5'd31, 5'd9, 5'd3, 5'd16
    };

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    potl_cmd_if cmd_ch ();
    potl_rsp_if rsp_ch ();

    priority_ordered_task_lists_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .rsp     (rsp_ch)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the task lists, kept in step with every accepted item.
    // ------------------------------------------------------------------
    logic [TASK_W-1:0] lk_next   [MAX_TASKS];
    logic [LIST_W-1:0] lk_member [MAX_TASKS];
    logic [PRIO_W-1:0] lk_prio   [MAX_TASKS];
    logic [TASK_W-1:0] lk_head   [NUM_LISTS];
    logic [CNT_W-1:0]  cfg_task_count;

    list_rsp_t pending_results [$];
    int        errors;

    // Idle controls shared with the two channel processes.
    bit gap_en;       // sender inserts random gaps
    bit stall_en;     // receiver drops ready in random bursts
    bit hold_req;     // receiver: one long hold-off

    // Applies one command to the shadow lists and returns the result it produces.
    function automatic list_rsp_t apply_list_command(input list_cmd_t c);
        list_rsp_t         r;
        logic [LIST_W-1:0] l;
        logic [LIST_W-1:0] m;
        int                t;
        int                cur;
        int                prev;
        int                steps;
        bit                tid_ok;
        bit                linked;

        l      = LIST_W'(int'(c.lid) % NUM_LISTS);
        t      = int'(c.tid);
        tid_ok = (t < int'(cfg_task_count)) && (t < MAX_TASKS);
        r.status = ST_DONE;
        r.lst    = NO_LIST;
        r.head   = lk_head[l];

        case (c.op)
            CMD_INSERT:
            begin
                if (!tid_ok)
                    r.status = ST_INVALID;
                else if (lk_member[t] == l)
                begin
                    r.status = ST_ALREADY;
                    r.lst    = l;
                end
                else if (lk_member[t] < NUM_LISTS)
                begin
                    r.status = ST_OTHER;
                    r.lst    = lk_member[t];
                end
                else
                begin
                    // skip every entry with priority >= new one, so ties stay FIFO
                    prev  = MAX_TASKS;
                    cur   = int'(lk_head[l]);
                    steps = 0;
                    while (cur < MAX_TASKS && lk_prio[cur] >= c.prio && steps < MAX_TASKS)
                    begin
                        prev  = cur;
                        cur   = int'(lk_next[cur]);
                        steps++;
                    end
                    lk_prio[t] = c.prio;
                    lk_next[t] = TASK_W'(cur);
                    if (prev >= MAX_TASKS)
                        lk_head[l] = TASK_W'(t);
                    else
                        lk_next[prev] = TASK_W'(t);
                    lk_member[t] = l;
                    r.lst  = l;
                    r.head = lk_head[l];
                end
            end
            CMD_REMOVE:
            begin
                if (t == 0)
                begin
                    // idle task is checked before validity
                    r.status = ST_IDLE_RM;
                    r.lst    = lk_member[0];
                end
                else if (!tid_ok)
                    r.status = ST_INVALID;
                else if (lk_member[t] >= NUM_LISTS)
                    r.status = ST_NOT_IN;
                else
                begin
                    m   = lk_member[t];
                    cur = int'(lk_head[m]);
                    if (cur == t)
                        lk_head[m] = lk_next[t];
                    else
                    begin
                        linked = 1'b0;
                        steps  = 0;
                        while (!linked && cur < MAX_TASKS && steps < MAX_TASKS)
                        begin
                            if (int'(lk_next[cur]) == t)
                            begin
                                lk_next[cur] = lk_next[t];
                                linked = 1'b1;
                            end
                            else
                                cur = int'(lk_next[cur]);
                            steps++;
                        end
                    end
                    lk_next[t]   = NO_TASK;
                    lk_member[t] = NO_LIST;
                    r.head = lk_head[m];
                end
            end
            default:
                ;   // read head, in either encoding: head of list_id already set
        endcase
        return r;
    endfunction

    // Random command: well-formed most of the time, with ties in priority and
    // a bias toward list 0 so the walks get long.
    function automatic list_cmd_t pick_random_command();
        list_cmd_t c;
        int        roll;
        int        lim;

        lim  = (cfg_task_count > MAX_TASKS) ? MAX_TASKS : int'(cfg_task_count);
        roll = $urandom_range(0, 99);
        if (roll < 42)
            c.op = CMD_INSERT;
        else if (roll < 80)
            c.op = CMD_REMOVE;
        else if (roll < 95)
            c.op = CMD_READ;
        else
            c.op = CMD_READ_ALT;
        if ($urandom_range(0, 7) == 0)
            c.tid = TID_W'($urandom_range(0, 15));          // often out of range
        else
            c.tid = TID_W'($urandom_range(0, lim - 1));
        c.lid  = ($urandom_range(0, 2) == 0) ? LID_W'(0) : LID_W'($urandom_range(0, 3));
        c.prio = ($urandom_range(0, 1) == 1) ? PRIO_W'($urandom_range(0, 3) * 85)
                                              : PRIO_W'($urandom_range(0, 255));
        return c;
    endfunction

    // Offers one item and waits for it to be taken. Valid stays high afterwards,
    // so back-to-back items go out without a bubble; callers lower it when idle.
    task automatic offer_command(input list_cmd_t c, input bit typed, input list_rsp_t want);
        list_rsp_t got;

        if (gap_en && $urandom_range(0, 5) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= c.op;
        cmd_ch.task_id      <= c.tid;
        cmd_ch.list_id      <= c.lid;
        cmd_ch.priority_req <= c.prio;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        got = apply_list_command(c);
        pending_results.push_back(typed ? want : got);
    endtask

    // Sender stops and waits until every expected result is back.
    task automatic settle_lists();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // APB write of task_count, then a read-back of the same register.
    task automatic program_task_count(input logic [CNT_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TASK_COUNT;
        pwdata  <= APB_DW'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        cfg_task_count = v;
        // straight into the setup phase of the read
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CNT_W-1:0] !== v)
        begin
            $display("%0t: task_count read back expected %0d got %0d", $time, v,
                     prdata[CNT_W-1:0]);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request.
    // ------------------------------------------------------------------
    always
    begin
        @(posedge clk);
        if (hold_req)
        begin
            hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clk);
            rsp_ch.ready <= 1'b1;
        end
        else if (stall_en && $urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
            rsp_ch.ready <= 1'b1;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        list_rsp_t want;

        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d head %0d list %0d", $time,
                         rsp_ch.status, rsp_ch.head_task, rsp_ch.task_list);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.head_task !== want.head)
                begin
                    $display("%0t: head_task expected %0d got %0d", $time, want.head,
                             rsp_ch.head_task);
                    errors++;
                end
                if (rsp_ch.task_list !== want.lst)
                begin
                    $display("%0t: task_list expected %0d got %0d", $time, want.lst,
                             rsp_ch.task_list);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the APB port counts as progress.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        list_cmd_t c;
        int        i;
        int        ph;
        int        n;
        int        per_phase;

        // every input known from time 0
        rst_n               <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= CMD_READ;
        cmd_ch.task_id      <= '0;
        cmd_ch.list_id      <= '0;
        cmd_ch.priority_req <= '0;
        rsp_ch.ready        <= 1'b0;
        errors      = 0;
        gap_en      = 1'b0;
        stall_en    = 1'b0;
        hold_req    = 1'b0;

        // shadow state matches the block after reset
        cfg_task_count = TASK_COUNT_RST;
        for (i = 0; i < MAX_TASKS; i++)
        begin
            lk_next[i]   = NO_TASK;
            lk_member[i] = NO_LIST;
            lk_prio[i]   = '0;
        end
        for (i = 0; i < NUM_LISTS; i++)
            lk_head[i] = NO_TASK;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Idling is on so gaps hit the very first items too.
        gap_en   = 1'b1;
        stall_en = 1'b1;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_CFG)
            begin
                settle_lists();
                program_task_count(DIR_TABLE[i].cfgv);
            end
            else
            begin
                c.op   = DIR_TABLE[i].op;
                c.tid  = DIR_TABLE[i].tid;
                c.lid  = DIR_TABLE[i].lid;
                c.prio = DIR_TABLE[i].prio;
                offer_command(c, DIR_TABLE[i].typed, DIR_TABLE[i].want);
            end
        end

        // Random phases, one task_count setting each. The last one runs flat out.
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle_lists();
            program_task_count(PHASE_COUNT[ph]);
            gap_en    = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            stall_en  = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
            per_phase = (PHASE_COUNT[ph] == 5'd1) ? 60 : 120;
            for (n = 0; n < per_phase; n++)
            begin
                // Pressure: long receiver hold-off while items keep coming
                // back to back, so the block backs up into its input.
                if (ph == 1 && n == 50)
                begin
                    hold_req = 1'b1;
                    gap_en   = 1'b0;
                end
                if (ph == 1 && n == 62)
                    gap_en = 1'b1;
                offer_command(pick_random_command(), 1'b0, '0);
            end
        end

        settle_lists();
        repeat (DRAIN_TAIL) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
